[sv/assert_macros.svh]
// Concurrent assertion helpers on clk, disabled or not by rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/nia_pkg.sv]
package nia_pkg;

  localparam int FREE_DEPTH = 64;
  localparam int MAX_BATCH  = 64;
  localparam int NAME_W     = 32;
  localparam int BATCH_W    = 7;
  localparam int ADDR_W     = $clog2(FREE_DEPTH);
  localparam int CNT_W      = $clog2(FREE_DEPTH + 1);
  localparam int RUN_W      = $clog2(MAX_BATCH + 1);

  localparam logic [NAME_W-1:0] NAME_LIMIT = '1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RESERVE = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_ALLOC_OUT,
    S_RESERVE,
    S_RELEASE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESULT
  } state_t;

  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                 input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (ADDR_W+1)'(FREE_DEPTH)) begin
      sum = sum - (ADDR_W+1)'(FREE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

[sv/nia_ram.sv]
module nia_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/name_id_allocator.sv]
// Allocate gives a name from the counter every cycle while the output is not stalled, and
//   one from the free list by a free-list RAM read and then the result register.
// Reserve reads and compares each free-list entry searched, then reads and writes each
//   entry shifted down after a hit; release writes the list tail. One transfer in at a time.
// Reset (synchronous) clears the counter, the list head and the list count; list RAM
//   contents are not cleared, and entries past the count are never read.
`include "assert_macros.svh"

module name_id_allocator import nia_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [NAME_W-1:0]  name_value,
  input  logic [BATCH_W-1:0] batch_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [NAME_W-1:0]  out_name,
  output logic [1:0]         status,
  output logic               last_of_run
);

  state_t state, state_next;

  logic [NAME_W-1:0] high_water;
  logic [NAME_W-1:0] cur_name;
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] idx;
  logic [CNT_W-1:0]  free_count;
  logic [RUN_W-1:0]  remaining;
  logic [RUN_W-1:0]  batch_sat;
  logic [1:0]        res_status;
  logic [CNT_W:0]    idx_p1;
  logic [CNT_W:0]    idx_p2;

  logic              slot_free;
  logic              hw_full;
  logic              list_empty;
  logic              hit;
  logic              accept;
  logic              last_one;

  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [NAME_W-1:0] mem_rd_data;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [NAME_W-1:0] mem_wr_data;

  logic              load;
  logic [NAME_W-1:0] ld_name;
  logic [1:0]        ld_status;
  logic              ld_last;

  nia_ram #(
    .DEPTH(FREE_DEPTH),
    .WIDTH(NAME_W)
  ) u_free_ram (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign slot_free  = !out_valid || out_ready;
  assign hw_full    = high_water >= (NAME_LIMIT - NAME_W'(1));
  assign list_empty = (free_count == '0);
  assign hit        = (mem_rd_data == cur_name);
  assign last_one   = (remaining == RUN_W'(1));
  assign idx_p1     = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
  assign idx_p2     = (CNT_W+1)'(idx) + (CNT_W+1)'(2);
  assign batch_sat  = (batch_count > BATCH_W'(MAX_BATCH)) ? RUN_W'(MAX_BATCH)
                                                           : RUN_W'(batch_count);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(opcode))
            OP_ALLOC:   if (batch_count != '0) state_next = S_ALLOC;
            OP_RESERVE: state_next = S_RESERVE;
            OP_RELEASE: state_next = S_RELEASE;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ALLOC: begin
        if (!list_empty) begin
          state_next = S_ALLOC_OUT;
        end else if (slot_free && last_one) begin
          state_next = S_IDLE;
        end
      end
      S_ALLOC_OUT: begin
        if (slot_free) begin
          state_next = last_one ? S_IDLE : S_ALLOC;
        end
      end
      S_RESERVE: begin
        if (cur_name >= high_water || list_empty) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_SRCH_RD;
        end
      end
      S_RELEASE:  state_next = S_RESULT;
      S_SRCH_RD:  state_next = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (hit) begin
          state_next = (idx_p1 < {1'b0, free_count}) ? S_SHIFT_RD : S_RESULT;
        end else begin
          state_next = (idx_p1 < {1'b0, free_count}) ? S_SRCH_RD : S_RESULT;
        end
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: state_next = (idx_p2 < {1'b0, free_count}) ? S_SHIFT_RD : S_RESULT;
      S_RESULT: begin
        if (slot_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = head;
    mem_wr_en   = 1'b0;
    mem_wr_addr = wrap_add(head, idx);
    mem_wr_data = cur_name;
    load        = 1'b0;
    ld_name     = '0;
    ld_status   = ST_OK;
    ld_last     = 1'b1;
    case (state)
      S_ALLOC: begin
        if (!list_empty) begin
          mem_rd_en = 1'b1;
        end else if (slot_free) begin
          load      = 1'b1;
          ld_name   = hw_full ? '0 : high_water + NAME_W'(1);
          ld_status = hw_full ? ST_EXHAUSTED : ST_OK;
          ld_last   = last_one;
        end
      end
      S_ALLOC_OUT: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_name = mem_rd_data;
          ld_last = last_one;
        end
      end
      S_RELEASE: begin
        mem_wr_en   = (cur_name != '0) && (free_count < CNT_W'(FREE_DEPTH));
        mem_wr_addr = wrap_add(head, free_count[ADDR_W-1:0]);
      end
      S_SRCH_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = wrap_add(head, idx);
      end
      S_SHIFT_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = wrap_add(head, idx_p1[ADDR_W-1:0]);
      end
      S_SHIFT_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = mem_rd_data;
      end
      S_RESULT: begin
        load      = slot_free;
        ld_status = res_status;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      high_water <= '0;
      free_count <= '0;
      head       <= '0;
      remaining  <= '0;
      idx        <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            remaining <= batch_sat;
            idx       <= '0;
          end
        end
        S_ALLOC: begin
          if (list_empty && slot_free) begin
            if (!hw_full) high_water <= high_water + NAME_W'(1);
            remaining <= remaining - RUN_W'(1);
          end
        end
        S_ALLOC_OUT: begin
          if (slot_free) begin
            head       <= wrap_add(head, ADDR_W'(1));
            free_count <= free_count - CNT_W'(1);
            remaining  <= remaining - RUN_W'(1);
          end
        end
        S_RESERVE: begin
          if (cur_name >= high_water && !hw_full) begin
            high_water <= high_water + NAME_W'(1);
          end
        end
        S_RELEASE: begin
          if (mem_wr_en) free_count <= free_count + CNT_W'(1);
        end
        S_SRCH_CMP: begin
          if (hit) begin
            if (!(idx_p1 < {1'b0, free_count})) free_count <= free_count - CNT_W'(1);
          end else if (idx_p1 < {1'b0, free_count}) begin
            idx <= idx + ADDR_W'(1);
          end
        end
        S_SHIFT_WR: begin
          idx <= idx + ADDR_W'(1);
          if (!(idx_p2 < {1'b0, free_count})) free_count <= free_count - CNT_W'(1);
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_name   <= name_value;
      res_status <= ST_OK;
    end else if (state == S_RESERVE && cur_name >= high_water && hw_full) begin
      res_status <= ST_EXHAUSTED;
    end else if (state == S_RELEASE && cur_name != '0
                 && free_count >= CNT_W'(FREE_DEPTH)) begin
      res_status <= ST_FULL;
    end
    if (load) begin
      out_name    <= ld_name;
      status      <= ld_status;
      last_of_run <= ld_last;
    end
  end

  `ASSERT_CLK(a_count_bound, free_count <= CNT_W'(FREE_DEPTH), "free list count past depth")
  `ASSERT_CLK(a_hw_limit, high_water != NAME_LIMIT, "high water reached name limit")
  `ASSERT_ALWAYS(a_no_overwrite, load |-> (!out_valid || out_ready), "result overwritten")
  `ASSERT_CLK(a_release_count, state == S_RELEASE && mem_wr_en |=>
              free_count == $past(free_count) + CNT_W'(1), "release did not grow list")

endmodule
